/* rtl/sme_pkg.sv */
`default_nettype none
package sme_pkg;

   typedef enum logic [4:0] {
      OP_PUSH_IMM   = 5'd0,
      OP_PUSH_PI    = 5'd1,
      OP_ADD        = 5'd2,
      OP_SUB        = 5'd3,
      OP_MUL        = 5'd4,
      OP_DIV        = 5'd5,
      OP_REM        = 5'd6,
      OP_CMPG       = 5'd7,
      OP_CMPL       = 5'd8,
      OP_CMPLE      = 5'd9,
      OP_PRINT      = 5'd10,
      OP_SET        = 5'd11,
      OP_GET        = 5'd12,
      OP_JUMPZ      = 5'd13,
      OP_JUMP       = 5'd14,
      OP_PUSH_TRUE  = 5'd15,
      OP_PUSH_FALSE = 5'd16,
      OP_NOP        = 5'd17,
      OP_IS_EVEN    = 5'd18,
      OP_NEGATE     = 5'd19,
      OP_END        = 5'd20
   } opcode_type;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_UNDER   = 3'd1;
   localparam logic [2:0] ST_OVER    = 3'd2;
   localparam logic [2:0] ST_DIVZ    = 3'd3;
   localparam logic [2:0] ST_BADBOOL = 3'd4;

   localparam logic [31:0] PI_VALUE = 32'd3;

   // stack count field is 7 bits, var index is taken modulo VAR_COUNT
   localparam int STACK_DEPTH = 64;
   localparam int VAR_COUNT   = 16;

   typedef struct packed {
      logic [4:0]         cmd;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               jump_taken;
      logic [15:0]        jump_target;
      logic               print_valid;
      logic signed [31:0] print_value;
      logic [6:0]         stack_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;   // capture request, start stack reads
      logic div_start;
      logic div_step;
      logic mul_step;
      logic commit;     // write back and build response
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_div;     // div or rem with two operands and nonzero divisor
      logic is_mul;
      logic div_last;
   } dp_status_type;

endpackage
`default_nettype wire

/* rtl/sme_datapath.sv */
`default_nettype none
module sme_datapath #(
   parameter int ADDR_BITS   = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire sme_pkg::req_type       req_in,
   input  wire sme_pkg::dp_cmd_type    cmd_in,
   output sme_pkg::dp_status_type      status_out,
   output sme_pkg::rsp_type            rsp_out
);

   localparam int SP_BITS  = $clog2(sme_pkg::STACK_DEPTH + 1);
   localparam int IDX_BITS = (sme_pkg::STACK_DEPTH > 1) ? $clog2(sme_pkg::STACK_DEPTH) : 1;
   localparam int VAR_BITS = (sme_pkg::VAR_COUNT > 1) ? $clog2(sme_pkg::VAR_COUNT) : 1;
   localparam int TGT_BITS = (ADDR_BITS < 16) ? ADDR_BITS : 16;

   logic [31:0] stack_mem [sme_pkg::STACK_DEPTH];
   logic [31:0] var_mem [sme_pkg::VAR_COUNT];
   logic [sme_pkg::VAR_COUNT-1:0] var_valid_ff;

   logic [SP_BITS-1:0] sp_ff;
   logic [4:0]  cmd_ff;
   logic [31:0] opnd_ff;
   logic [31:0] a_ff, b_ff, var_rd_ff;

   // the var index is the operand modulo VAR_COUNT
   logic [VAR_BITS-1:0] var_idx;
   logic [VAR_BITS-1:0] var_idx_ff;
   always_comb begin
      var_idx = VAR_BITS'($unsigned(req_in.operand) % 32'(sme_pkg::VAR_COUNT));
   end

   logic [IDX_BITS-1:0] idx_top, idx_next;
   always_comb begin
      idx_top  = IDX_BITS'(sp_ff - SP_BITS'(1));
      idx_next = IDX_BITS'(sp_ff - SP_BITS'(2));
   end

   always_ff @(posedge clock) begin
      if (cmd_in.load_req) begin
         cmd_ff     <= req_in.cmd;
         opnd_ff    <= req_in.operand;
         var_idx_ff <= var_idx;
         a_ff       <= stack_mem[idx_top];
         b_ff       <= stack_mem[idx_next];
         var_rd_ff  <= var_valid_ff[var_idx] ? var_mem[var_idx] : 32'd0;
      end
   end

   logic have1, have2, full;
   always_comb begin
      have1 = (sp_ff >= SP_BITS'(1));
      have2 = (sp_ff >= SP_BITS'(2));
      full  = (sp_ff >= SP_BITS'(sme_pkg::STACK_DEPTH));
   end

   // radix-2 restoring divider on magnitudes
   logic [31:0] dq_ff, dr_ff, dd_ff;
   logic [5:0]  dcnt_ff;
   logic [32:0] trial;
   logic [31:0] mag_a, mag_b;
   always_comb begin
      mag_a = a_ff[31] ? (32'd0 - a_ff) : a_ff;
      mag_b = b_ff[31] ? (32'd0 - b_ff) : b_ff;
      trial = {dr_ff, dq_ff[31]} - {1'b0, dd_ff};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= 6'd0;
      end else if (cmd_in.div_start) begin
         dcnt_ff <= 6'd0;
      end else if (cmd_in.div_step) begin
         dcnt_ff <= dcnt_ff + 6'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd_in.div_start) begin
         dq_ff <= mag_b;
         dr_ff <= 32'd0;
         dd_ff <= mag_a;
      end else if (cmd_in.div_step) begin
         if (!trial[32]) begin
            dr_ff <= trial[31:0];
            dq_ff <= {dq_ff[30:0], 1'b1};
         end else begin
            dr_ff <= {dr_ff[30:0], dq_ff[31]};
            dq_ff <= {dq_ff[30:0], 1'b0};
         end
      end
   end

   logic [31:0] mul_ff;
   always_ff @(posedge clock) begin
      if (cmd_in.mul_step) begin
         mul_ff <= a_ff * b_ff;
      end
   end

   always_comb begin
      status_out.is_div = have2 && (a_ff != 32'd0) &&
         (cmd_ff == sme_pkg::OP_DIV || cmd_ff == sme_pkg::OP_REM);
      status_out.is_mul = have2 && (cmd_ff == sme_pkg::OP_MUL);
      status_out.div_last = (dcnt_ff == 6'd31) && cmd_in.div_step;
   end

   // result evaluation
   logic [2:0]  st;
   logic        jt, pv, wr_en, var_wr;
   logic [IDX_BITS-1:0] wr_idx;
   logic [31:0] wr_data, pval;
   logic [SP_BITS-1:0] sp_new;
   logic [15:0] jtgt;
   logic gt_ba, gt_ab;
   always_comb begin
      gt_ba = $signed(b_ff) > $signed(a_ff);
      gt_ab = $signed(a_ff) > $signed(b_ff);
      st = sme_pkg::ST_OK;
      jt = 1'b0;
      jtgt = 16'd0;
      pv = 1'b0;
      pval = 32'd0;
      wr_en = 1'b0;
      var_wr = 1'b0;
      wr_idx = idx_next;
      wr_data = 32'd0;
      sp_new = sp_ff;
      unique case (cmd_ff)
         sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
         sme_pkg::OP_REM, sme_pkg::OP_CMPG, sme_pkg::OP_CMPL,
         sme_pkg::OP_CMPLE: begin
            if (!have2) begin
               st = sme_pkg::ST_UNDER;
            end else if ((cmd_ff == sme_pkg::OP_DIV || cmd_ff == sme_pkg::OP_REM)
                         && a_ff == 32'd0) begin
               st = sme_pkg::ST_DIVZ;
            end else begin
               wr_en = 1'b1;
               sp_new = sp_ff - SP_BITS'(1);
               unique case (cmd_ff)
                  sme_pkg::OP_ADD:  wr_data = a_ff + b_ff;
                  sme_pkg::OP_SUB:  wr_data = b_ff - a_ff;
                  sme_pkg::OP_MUL:  wr_data = mul_ff;
                  sme_pkg::OP_DIV:
                     wr_data = (a_ff[31] ^ b_ff[31]) ? (32'd0 - dq_ff) : dq_ff;
                  sme_pkg::OP_REM:
                     wr_data = b_ff[31] ? (32'd0 - dr_ff) : dr_ff;
                  sme_pkg::OP_CMPG: wr_data = gt_ba ? 32'd0 : 32'd1;
                  sme_pkg::OP_CMPL: wr_data = gt_ab ? 32'd0 : 32'd1;
                  default:          wr_data = gt_ba ? 32'd1 : 32'd0;
               endcase
            end
         end
         sme_pkg::OP_PUSH_IMM, sme_pkg::OP_PUSH_PI, sme_pkg::OP_PUSH_TRUE,
         sme_pkg::OP_PUSH_FALSE, sme_pkg::OP_GET: begin
            if (full) begin
               st = sme_pkg::ST_OVER;
            end else begin
               wr_en = 1'b1;
               wr_idx = IDX_BITS'(sp_ff);
               sp_new = sp_ff + SP_BITS'(1);
               unique case (cmd_ff)
                  sme_pkg::OP_PUSH_IMM:  wr_data = opnd_ff;
                  sme_pkg::OP_PUSH_PI:   wr_data = sme_pkg::PI_VALUE;
                  sme_pkg::OP_PUSH_TRUE: wr_data = 32'd0;
                  sme_pkg::OP_PUSH_FALSE: wr_data = 32'd1;
                  default:               wr_data = var_rd_ff;
               endcase
            end
         end
         sme_pkg::OP_PRINT, sme_pkg::OP_END: begin
            if (!have1) begin
               st = sme_pkg::ST_UNDER;
            end else begin
               pv = 1'b1;
               pval = a_ff;
               if (cmd_ff == sme_pkg::OP_END) sp_new = sp_ff - SP_BITS'(1);
            end
         end
         sme_pkg::OP_SET: begin
            if (!have1) st = sme_pkg::ST_UNDER;
            else begin
               var_wr = 1'b1;
               sp_new = sp_ff - SP_BITS'(1);
            end
         end
         sme_pkg::OP_JUMPZ: begin
            if (!have1) st = sme_pkg::ST_UNDER;
            else begin
               sp_new = sp_ff - SP_BITS'(1);
               if (a_ff == 32'd1) begin
                  jt = 1'b1;
                  jtgt = 16'(opnd_ff[TGT_BITS-1:0]);
               end
            end
         end
         sme_pkg::OP_JUMP: begin
            jt = 1'b1;
            jtgt = 16'(opnd_ff[TGT_BITS-1:0]);
         end
         sme_pkg::OP_IS_EVEN: begin
            if (!have1) st = sme_pkg::ST_UNDER;
            else begin
               wr_en = 1'b1;
               wr_idx = idx_top;
               wr_data = a_ff[0] ? (a_ff[31] ? 32'hFFFF_FFFF : 32'd1) : 32'd0;
            end
         end
         sme_pkg::OP_NEGATE: begin
            if (!have1) st = sme_pkg::ST_UNDER;
            else if (a_ff == 32'd0 || a_ff == 32'd1) begin
               wr_en = 1'b1;
               wr_idx = idx_top;
               wr_data = {31'd0, ~a_ff[0]};
            end else begin
               st = sme_pkg::ST_BADBOOL;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd_in.commit && wr_en) stack_mem[wr_idx] <= wr_data;
      if (cmd_in.commit && var_wr) var_mem[var_idx_ff] <= a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
         var_valid_ff <= '0;
      end else if (cmd_in.commit) begin
         sp_ff <= sp_new;
         if (var_wr) var_valid_ff[var_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_in.commit) begin
         rsp_out.status      <= st;
         rsp_out.jump_taken  <= jt;
         rsp_out.jump_target <= jtgt;
         rsp_out.print_valid <= pv;
         rsp_out.print_value <= pval;
         rsp_out.stack_count <= 7'(sp_new);
      end
   end

endmodule
`default_nettype wire

/* rtl/sme_control.sv */
`default_nettype none
module sme_control (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   input  wire sme_pkg::dp_status_type status_in,
   output sme_pkg::dp_cmd_type         cmd_out
);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_MUL, S_DIV, S_COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // a request is taken while idle, even with a response still waiting
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      rsp_valid = rsp_valid_ff;
      cmd_out.load_req  = req_valid && (state_ff == S_IDLE);
      cmd_out.div_start = (state_ff == S_DECODE) && status_in.is_div;
      cmd_out.div_step  = (state_ff == S_DIV);
      cmd_out.mul_step  = (state_ff == S_MUL);
      cmd_out.commit    = (state_ff == S_COMMIT) && !(rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd_out.commit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_DECODE;
            S_DECODE: begin
               priority if (status_in.is_div) state_ff <= S_DIV;
               else if (status_in.is_mul) state_ff <= S_MUL;
               else state_ff <= S_COMMIT;
            end
            S_MUL: state_ff <= S_COMMIT;
            S_DIV: if (status_in.div_last) state_ff <= S_COMMIT;
            S_COMMIT: begin
               if (cmd_out.commit) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* rtl/stack_machine_executor.sv */
`default_nettype none
// channel   ports                          direction
// request   req_valid req_stall req_data   in
// response  rsp_valid rsp_stall rsp_data   out
// a request is taken only while idle, then passes decode, a mul step or a 32-step
// radix-2 divider for div and rem, and commit, where the response is registered.
// reset is synchronous: stack empty, variable store reads as zero.
// a stalled response holds; the next request's result waits until it is taken.
module stack_machine_executor #(
   parameter int ADDR_BITS   = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire sme_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output sme_pkg::rsp_type       rsp_data
);

   sme_pkg::dp_cmd_type    dp_cmd;
   sme_pkg::dp_status_type dp_status;

   sme_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status_in (dp_status),
      .cmd_out   (dp_cmd)
   );

   sme_datapath #(
      .ADDR_BITS   (ADDR_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_in     (req_data),
      .cmd_in     (dp_cmd),
      .status_out (dp_status),
      .rsp_out    (rsp_data)
   );

   a_no_commit_on_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !dp_cmd.commit)
      else $error("response overwritten while stalled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.stack_count) <= 32'(sme_pkg::STACK_DEPTH)))
      else $error("stack count beyond depth");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_req |=> req_stall)
      else $error("request taken while busy");

endmodule
`default_nettype wire

/* tb/stack_machine_executor_tb.sv */
`default_nettype none
module stack_machine_executor_tb;

   localparam int DEPTH = sme_pkg::STACK_DEPTH;
   localparam int NVARS = sme_pkg::VAR_COUNT;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sme_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sme_pkg::rsp_type rsp_data;

   stack_machine_executor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // machine state as the block should hold it
   logic [31:0] mdl_stack [DEPTH];
   logic [31:0] mdl_vars [NVARS];
   int unsigned mdl_sp;
   sme_pkg::rsp_type expected_rsps [$];
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned sent = 0;
   int unsigned checked = 0;
   int unsigned status_seen [5];
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   function automatic logic [31:0] magnitude(logic [31:0] x);
      return x[31] ? 32'd0 - x : x;
   endfunction

   function automatic sme_pkg::rsp_type execute(sme_pkg::req_type r);
      sme_pkg::rsp_type o;
      logic [31:0] a, b, v, res, opnd;
      int unsigned sp;
      int unsigned vi;
      o = '0;
      sp = mdl_sp;
      opnd = r.operand;
      vi = opnd % NVARS;
      res = '0;
      if (r.cmd >= sme_pkg::OP_ADD && r.cmd <= sme_pkg::OP_CMPLE) begin
         if (sp < 2) begin
            o.status = sme_pkg::ST_UNDER;
         end else begin
            a = mdl_stack[sp-1];
            b = mdl_stack[sp-2];
            case (r.cmd)
               sme_pkg::OP_ADD: res = a + b;
               sme_pkg::OP_SUB: res = b - a;
               sme_pkg::OP_MUL: res = a * b;
               sme_pkg::OP_DIV: res = ((a ^ b) & 32'h8000_0000) != 0 ?
                  32'd0 - magnitude(b) / magnitude(a) : magnitude(b) / magnitude(a);
               sme_pkg::OP_REM: res = b[31] ? 32'd0 - magnitude(b) % magnitude(a)
                                            : magnitude(b) % magnitude(a);
               sme_pkg::OP_CMPG: res = ($signed(b) > $signed(a)) ? 0 : 1;
               sme_pkg::OP_CMPL: res = ($signed(a) > $signed(b)) ? 0 : 1;
               default: res = ($signed(b) > $signed(a)) ? 1 : 0;
            endcase
            if ((r.cmd == sme_pkg::OP_DIV || r.cmd == sme_pkg::OP_REM) && a == 0) begin
               o.status = sme_pkg::ST_DIVZ;
            end else begin
               mdl_stack[sp-2] = res;
               mdl_sp = sp - 1;
            end
         end
      end else begin
         case (r.cmd)
            sme_pkg::OP_PUSH_IMM, sme_pkg::OP_PUSH_PI, sme_pkg::OP_PUSH_TRUE,
            sme_pkg::OP_PUSH_FALSE, sme_pkg::OP_GET: begin
               case (r.cmd)
                  sme_pkg::OP_PUSH_IMM: v = opnd;
                  sme_pkg::OP_PUSH_PI: v = sme_pkg::PI_VALUE;
                  sme_pkg::OP_PUSH_TRUE: v = 0;
                  sme_pkg::OP_PUSH_FALSE: v = 1;
                  default: v = mdl_vars[vi];
               endcase
               if (sp >= DEPTH) o.status = sme_pkg::ST_OVER;
               else begin
                  mdl_stack[sp] = v;
                  mdl_sp = sp + 1;
               end
            end
            sme_pkg::OP_PRINT, sme_pkg::OP_END: begin
               if (sp == 0) o.status = sme_pkg::ST_UNDER;
               else begin
                  o.print_valid = 1'b1;
                  o.print_value = mdl_stack[sp-1];
                  if (r.cmd == sme_pkg::OP_END) mdl_sp = sp - 1;
               end
            end
            sme_pkg::OP_SET: begin
               if (sp == 0) o.status = sme_pkg::ST_UNDER;
               else begin
                  mdl_vars[vi] = mdl_stack[sp-1];
                  mdl_sp = sp - 1;
               end
            end
            sme_pkg::OP_JUMPZ: begin
               if (sp == 0) o.status = sme_pkg::ST_UNDER;
               else begin
                  if (mdl_stack[sp-1] == 1) begin
                     o.jump_taken = 1'b1;
                     o.jump_target = opnd[15:0];
                  end
                  mdl_sp = sp - 1;
               end
            end
            sme_pkg::OP_JUMP: begin
               o.jump_taken = 1'b1;
               o.jump_target = opnd[15:0];
            end
            sme_pkg::OP_IS_EVEN: begin
               if (sp == 0) o.status = sme_pkg::ST_UNDER;
               else begin
                  v = mdl_stack[sp-1];
                  mdl_stack[sp-1] = v[0] ? (v[31] ? 32'hFFFF_FFFF : 32'd1) : 32'd0;
               end
            end
            sme_pkg::OP_NEGATE: begin
               if (sp == 0) o.status = sme_pkg::ST_UNDER;
               else if (mdl_stack[sp-1] == 0) mdl_stack[sp-1] = 1;
               else if (mdl_stack[sp-1] == 1) mdl_stack[sp-1] = 0;
               else o.status = sme_pkg::ST_BADBOOL;
            end
            default: ;
         endcase
      end
      o.stack_count = mdl_sp[6:0];
      return o;
   endfunction

   // sender pacing: bursts with gaps, valid drops only for a gap or a drain
   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
      if (gap_left > 0) req_valid <= 1'b0;
      while (gap_left > 0) begin
         @(posedge clock);
         gap_left--;
      end
      burst_left--;
   endtask

   task automatic send_request(logic [4:0] cmd, logic [31:0] opnd);
      sme_pkg::req_type r;
      sme_pkg::rsp_type exp_item;
      r.cmd = cmd;
      r.operand = opnd;
      pace_sender();
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      exp_item = execute(r);
      expected_rsps.insert(expected_rsps.size(), exp_item);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return $urandom_range(0, 1);
         4: return 32'd0 - $urandom_range(0, 9);
         5: return $urandom_range(0, 40);
         default: return $urandom;
      endcase
   endfunction

   // receiver stall pattern and result checking
   int unsigned stall_mode = 0;
   always @(posedge clock) begin
      sme_pkg::rsp_type exp_r;
      cycles++;
      if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= (cycles % 7) < 3;
      endcase
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("response with nothing expected");
            errors++;
         end else begin
            exp_r = expected_rsps.pop_front();
            checked++;
            if (exp_r.status < 5) status_seen[exp_r.status]++;
            if (rsp_data.status !== exp_r.status) begin
               $error("status exp %0d got %0d", exp_r.status, rsp_data.status); errors++;
            end
            if (rsp_data.jump_taken !== exp_r.jump_taken) begin
               $error("jump_taken exp %0d got %0d", exp_r.jump_taken, rsp_data.jump_taken);
               errors++;
            end
            if (rsp_data.jump_target !== exp_r.jump_target) begin
               $error("jump_target exp %0h got %0h", exp_r.jump_target,
                      rsp_data.jump_target);
               errors++;
            end
            if (rsp_data.print_valid !== exp_r.print_valid) begin
               $error("print_valid exp %0d got %0d", exp_r.print_valid,
                      rsp_data.print_valid);
               errors++;
            end
            if (rsp_data.print_value !== exp_r.print_value) begin
               $error("print_value exp %0h got %0h", exp_r.print_value,
                      rsp_data.print_value);
               errors++;
            end
            if (rsp_data.stack_count !== exp_r.stack_count) begin
               $error("stack_count exp %0d got %0d", exp_r.stack_count,
                      rsp_data.stack_count);
               errors++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic test_underflow_on_empty();
      sme_pkg::opcode_type op;
      for (int i = sme_pkg::OP_ADD; i <= sme_pkg::OP_END; i++) begin
         op = sme_pkg::opcode_type'(i);
         if (op != sme_pkg::OP_PUSH_TRUE && op != sme_pkg::OP_PUSH_FALSE &&
             op != sme_pkg::OP_GET)
            send_request(op, 32'hFFFF_FFFF);
      end
   endtask

   task automatic test_arith_corners();
      send_request(sme_pkg::OP_PUSH_IMM, 32'h8000_0000);
      send_request(sme_pkg::OP_PUSH_IMM, 32'hFFFF_FFFF);
      send_request(sme_pkg::OP_DIV, 0);
      send_request(sme_pkg::OP_PUSH_IMM, 32'h8000_0000);
      send_request(sme_pkg::OP_PUSH_IMM, 32'hFFFF_FFFF);
      send_request(sme_pkg::OP_REM, 0);
      send_request(sme_pkg::OP_PUSH_IMM, 0);
      send_request(sme_pkg::OP_DIV, 0);        // zero divisor
      send_request(sme_pkg::OP_PUSH_IMM, 32'h7FFF_FFFF);
      send_request(sme_pkg::OP_MUL, 0);
      send_request(sme_pkg::OP_PUSH_PI, 0);
      send_request(sme_pkg::OP_NEGATE, 0);     // not a boolean
      send_request(sme_pkg::OP_IS_EVEN, 0);
      send_request(sme_pkg::OP_SET, 32'hFFFF_FFFF);
      send_request(sme_pkg::OP_GET, 32'h8000_000F);
      send_request(sme_pkg::OP_PRINT, 0);
      send_request(sme_pkg::OP_JUMPZ, 32'h1234_ABCD);
      send_request(sme_pkg::OP_JUMP, 32'hFFFF_FFFF);
      send_request(5'd31, 0);         // unused opcode
      drain();
   endtask

   task automatic test_overflow();
      while (mdl_sp < DEPTH) send_request(sme_pkg::OP_PUSH_IMM, $urandom);
      send_request(sme_pkg::OP_PUSH_IMM, 1);
      send_request(sme_pkg::OP_PUSH_TRUE, 0);
      send_request(sme_pkg::OP_GET, 3);
      while (mdl_sp > 0) send_request(sme_pkg::OP_END, 0);
      send_request(sme_pkg::OP_END, 0);
      drain();
   endtask

   task automatic test_random_programs(int unsigned count);
      logic [4:0] cmd;
      for (int unsigned i = 0; i < count; i++) begin
         if (i == count / 2) drain();
         case ($urandom_range(0, 9))
            0, 1, 2: cmd = (mdl_sp < 3 || $urandom_range(0, 3) == 0) ?
                            sme_pkg::OP_PUSH_IMM :
                            5'($urandom_range(sme_pkg::OP_ADD, sme_pkg::OP_CMPLE));
            3: cmd = (mdl_sp > 50) ? sme_pkg::OP_END : sme_pkg::OP_PUSH_IMM;
            4: cmd = 5'($urandom_range(sme_pkg::OP_PUSH_TRUE, sme_pkg::OP_PUSH_FALSE));
            5: cmd = 5'($urandom_range(sme_pkg::OP_IS_EVEN, sme_pkg::OP_NEGATE));
            6: cmd = 5'($urandom_range(sme_pkg::OP_SET, sme_pkg::OP_JUMP));
            7: cmd = 5'($urandom_range(0, 31));
            default: cmd = 5'($urandom_range(sme_pkg::OP_ADD, sme_pkg::OP_REM));
         endcase
         send_request(cmd, rand_word());
      end
      drain();
   endtask

   initial begin
      mdl_sp = 0;
      for (int i = 0; i < NVARS; i++) mdl_vars[i] = '0;
      for (int i = 0; i < DEPTH; i++) mdl_stack[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_underflow_on_empty();
      test_arith_corners();
      test_overflow();
      test_random_programs(1100);
      repeat (60) @(posedge clock);
      $display("sent %0d requests, checked %0d responses", sent, checked);
      $display("status ok/under/over/divz/badbool: %0d %0d %0d %0d %0d", status_seen[0],
               status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire

/* stack_machine_executor.f */
rtl/sme_pkg.sv
rtl/sme_datapath.sv
rtl/sme_control.sv
rtl/stack_machine_executor.sv
tb/stack_machine_executor_tb.sv
